// File: sv/fla_pkg.sv
// shared constants for the free-list index allocator
// no dependencies; imported by free_list_index_allocator_core
`default_nettype none

package fla_pkg;

    localparam int POOL_SLOTS = 1024;
    localparam int IDX_W      = $clog2(POOL_SLOTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int MAX_W      = 11;

    // request kinds (s_tuser)
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CHECK   = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // register byte addresses
    localparam logic [2:0] ADDR_MAX_SLOTS = 3'd0;

endpackage

`default_nettype wire

// File: sv/free_list_index_allocator_core.sv
// slot-index allocator with a lifo free stack kept in block memory
// depends on fla_pkg
`default_nettype none

// Each request beat yields one result beat. A request is taken in ST_IDLE, in which
// the active-flag and free-stack memories are read; ST_EXEC then evaluates the request,
// writes both memories back and loads the output register once that register is free,
// and only then is the next request taken, as the memories are read ahead of the
// read-modify-write. While a result waits on m_tready one more request can be taken and
// read, but its evaluation holds until the waiting beat leaves and no request after it is
// taken. Both memories are left uninitialized after reset and need no clearing pass; only
// slots below the grown size, which have been written, are ever used.
module free_list_index_allocator_core
    import fla_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [9:0] slot_index, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [1:0] status, [11:2] granted_index,
                                        // [22:12] live_count, rest zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             state_reg, state_next;
    logic [1:0]       req_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] free_depth_reg, free_depth_next;
    logic [CNT_W-1:0] grown_size_reg, grown_size_next;
    logic [MAX_W-1:0] max_slots_reg;
    logic             out_valid_reg;
    logic [23:0]      out_data_reg;

    logic             active_mem [POOL_SLOTS];
    logic [IDX_W-1:0] stack_mem  [POOL_SLOTS];
    logic             active_rd;
    logic [IDX_W-1:0] stack_rd;

    logic             s_accept, out_free, exec_go;
    logic [CNT_W-1:0] bound;
    logic             idx_valid;
    logic             act_we, act_wdata;
    logic [IDX_W-1:0] act_waddr;
    logic             stk_we;
    logic [1:0]       status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] live;
    logic             cfg_wr;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign exec_go  = (state_reg == ST_EXEC) && out_free;

    assign bound = (max_slots_reg > MAX_W'(POOL_SLOTS)) ? CNT_W'(POOL_SLOTS)
                                                        : CNT_W'(max_slots_reg);
    assign idx_valid = ({1'b0, idx_reg} < grown_size_reg) && active_rd;

    // memories: read on accept, written when the request is evaluated
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            active_rd <= active_mem[s_tdata[IDX_W-1:0]];
            stack_rd  <= stack_mem[IDX_W'(free_depth_reg - 1'b1)];
        end
        if (act_we)
        begin
            active_mem[act_waddr] <= act_wdata;
        end
        if (stk_we)
        begin
            stack_mem[free_depth_reg[IDX_W-1:0]] <= idx_reg;
        end
    end

    always_comb
    begin
        free_depth_next = free_depth_reg;
        grown_size_next = grown_size_reg;
        act_we          = 1'b0;
        act_wdata       = 1'b0;
        act_waddr       = idx_reg;
        stk_we          = 1'b0;
        status          = ST_OK;
        granted         = '0;
        case (req_reg)
            REQ_ALLOC:
            begin
                if (free_depth_reg != '0)
                begin
                    free_depth_next = free_depth_reg - 1'b1;
                    granted         = stack_rd;
                    act_waddr       = stack_rd;
                    act_wdata       = 1'b1;
                    act_we          = exec_go;
                end
                else if (grown_size_reg < bound)
                begin
                    grown_size_next = grown_size_reg + 1'b1;
                    granted         = grown_size_reg[IDX_W-1:0];
                    act_waddr       = grown_size_reg[IDX_W-1:0];
                    act_wdata       = 1'b1;
                    act_we          = exec_go;
                end
                else
                begin
                    status = ST_FULL;
                end
            end
            REQ_RELEASE:
            begin
                if (idx_valid && (free_depth_reg < CNT_W'(POOL_SLOTS)))
                begin
                    free_depth_next = free_depth_reg + 1'b1;
                    act_we          = exec_go;
                    stk_we          = exec_go;
                end
                else
                begin
                    status = ST_BAD;
                end
            end
            REQ_CHECK:
            begin
                if (!idx_valid)
                begin
                    status = ST_BAD;
                end
            end
            default:
            begin
                free_depth_next = '0;
                grown_size_next = '0;
            end
        endcase
        live = grown_size_next - free_depth_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_depth_reg <= '0;
            grown_size_reg <= '0;
            max_slots_reg  <= MAX_W'(1024);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                free_depth_reg <= free_depth_next;
                grown_size_reg <= grown_size_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr && (paddr == ADDR_MAX_SLOTS))
            begin
                max_slots_reg <= pwdata[MAX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            req_reg <= s_tuser;
            idx_reg <= s_tdata[IDX_W-1:0];
        end
        if (exec_go)
        begin
            out_data_reg <= {1'b0, live, granted, status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_MAX_SLOTS) ? {{(32 - MAX_W){1'b0}}, max_slots_reg}
                                                : 32'd0;

    // stack never holds more indices than have been grown
    a_depth_le_grown: assert property (@(posedge clk) disable iff (!rst_n)
        free_depth_reg <= grown_size_reg)
        else $error("free stack deeper than grown size");

    a_grown_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        grown_size_reg <= CNT_W'(POOL_SLOTS))
        else $error("grown size beyond pool");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (!s_tready && (state_reg == ST_EXEC)))
        else $error("second request taken before evaluation");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> (m_tvalid && s_tready))
        else $error("evaluated request left no result beat");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && !out_free) |=> (state_reg == ST_EXEC))
        else $error("evaluation ran over a waiting result");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for free_list_index_allocator_core: random request bursts,
// result-side stalls and bound reprogramming, checked against a pool tracker class
// depends on fla_pkg and free_list_index_allocator_core

module tb_top;
    import fla_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;

    typedef struct {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted;
        logic [CNT_W-1:0] live;
    } slot_result_t;

    // tracks the pool contents and queues the result each request must produce
    class slot_pool_tracker;
        bit               in_use[POOL_SLOTS];
        logic [IDX_W-1:0] recycled[POOL_SLOTS];
        int unsigned      recycled_top;
        int unsigned      high_water;
        logic [MAX_W-1:0] bound_reg;
        slot_result_t     due_results[$];
        int               errors;

        function void wipe();
            foreach (in_use[i]) in_use[i] = 1'b0;
            recycled_top = 0;
            high_water   = 0;
            bound_reg    = MAX_W'(POOL_SLOTS);
            errors       = 0;
        endfunction

        function void take_request(logic [1:0] req, logic [IDX_W-1:0] idx);
            slot_result_t r;
            int unsigned  limit;
            r.status  = ST_OK;
            r.granted = '0;
            limit = (bound_reg < POOL_SLOTS) ? bound_reg : POOL_SLOTS;
            case (req)
                REQ_ALLOC:
                begin
                    if (recycled_top > 0)
                    begin
                        recycled_top--;
                        r.granted = recycled[recycled_top];
                        in_use[r.granted] = 1'b1;
                    end
                    else if (high_water < limit)
                    begin
                        r.granted = IDX_W'(high_water);
                        in_use[high_water] = 1'b1;
                        high_water++;
                    end
                    else
                        r.status = ST_FULL;
                end
                REQ_RELEASE:
                begin
                    if (idx < high_water && in_use[idx] && recycled_top < POOL_SLOTS)
                    begin
                        in_use[idx] = 1'b0;
                        recycled[recycled_top] = idx;
                        recycled_top++;
                    end
                    else
                        r.status = ST_BAD;
                end
                REQ_CHECK:
                begin
                    if (!(idx < high_water && in_use[idx]))
                        r.status = ST_BAD;
                end
                default:
                begin
                    recycled_top = 0;
                    high_water   = 0;
                end
            endcase
            r.live = CNT_W'(high_water - recycled_top);
            due_results.push_back(r);
        endfunction

        function void match_result(logic [23:0] beat);
            slot_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result beat 0x%06h with nothing outstanding", beat);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (beat[1:0] !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, beat[1:0]);
                errors++;
            end
            if (beat[11:2] !== want.granted)
            begin
                $error("granted_index: expected %0d, got %0d", want.granted, beat[11:2]);
                errors++;
            end
            if (beat[22:12] !== want.live)
            begin
                $error("live_count: expected %0d, got %0d", want.live, beat[22:12]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [9:0] slot_index, rest zero
    logic [1:0]  s_tuser  = '0;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [1:0] status, [11:2] granted_index, [22:12] live_count
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    slot_pool_tracker pool = new;
    int burst_left = 0;
    int quiet_cycles = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    free_list_index_allocator_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side stalls: a randomly redrawn mode sets m_tready
    initial
    begin
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 96 == 0)
                rx_mode = $urandom_range(2);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(9) < 6);
                default: m_tready <= ((rx_cycle % 7) < 4);
            endcase
        end
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                pool.match_result(m_tdata);
            if (s_tvalid && s_tready)
                pool.take_request(s_tuser, s_tdata[IDX_W-1:0]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("free_list_index_allocator_core verification failed");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic push_request(input logic [1:0] req, input logic [IDX_W-1:0] idx);
        int r;
        int gap;
        if (burst_left == 0)
        begin
            r = $urandom_range(9);
            gap = (r < 3) ? 0 : (r < 8) ? $urandom_range(5, 1) : $urandom_range(20, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(40, 1);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(16 - IDX_W){1'b0}}, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic settle_pool();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pool.due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_bound(input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_MAX_SLOTS;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pool.bound_reg = value[MAX_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {{(32 - MAX_W){1'b0}}, value[MAX_W-1:0]})
        begin
            $error("max_slots: expected %0d, got %0d", value[MAX_W-1:0], readback);
            pool.errors++;
        end
    endtask

    // mostly indices inside the grown pool so releases and checks hit live slots
    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(99) < 70 && pool.high_water > 0)
            return IDX_W'($urandom_range(pool.high_water - 1));
        return IDX_W'($urandom);
    endfunction

    task automatic run_mix(input int n, input int alloc_pct, input int release_pct,
                           input int clear_pct);
        int r;
        logic [1:0] req;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < alloc_pct)
                req = REQ_ALLOC;
            else if (r < alloc_pct + release_pct)
                req = REQ_RELEASE;
            else if (r < 100 - clear_pct)
                req = REQ_CHECK;
            else
                req = REQ_CLEAR;
            push_request(req, pick_index());
        end
    endtask

    initial
    begin
        logic [1:0]       dir_req[20];
        logic [IDX_W-1:0] dir_idx[20];
        int bound_tab[7];
        bit wipe_tab[7];
        int count_tab[7];
        int alloc_tab[7];
        int rel_tab[7];
        int clr_tab[7];

        dir_req = '{REQ_CHECK, REQ_RELEASE, REQ_RELEASE, REQ_ALLOC, REQ_ALLOC,
                    REQ_ALLOC, REQ_CHECK, REQ_CHECK, REQ_CHECK, REQ_RELEASE,
                    REQ_RELEASE, REQ_CHECK, REQ_RELEASE, REQ_ALLOC, REQ_ALLOC,
                    REQ_ALLOC, REQ_CLEAR, REQ_CHECK, REQ_ALLOC, REQ_RELEASE};
        dir_idx = '{10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0,
                    10'd512, 10'd1, 10'd1023, 10'd3, 10'd1,
                    10'd1, 10'd1, 10'd0, 10'd0, 10'd0,
                    10'd0, 10'd1023, 10'd0, 10'd0, 10'd512};
        bound_tab = '{0, 1, 2047, 5, 1024, 17, 0};
        wipe_tab  = '{1, 1, 0, 0, 1, 1, 0};
        count_tab = '{30, 40, 1200, 120, 100, 100, 60};
        alloc_tab = '{50, 50, 94, 40, 50, 50, 40};
        rel_tab   = '{25, 25, 4, 40, 25, 30, 30};
        clr_tab   = '{3, 3, 0, 2, 3, 3, 2};

        pool.wipe();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty pool, lifo reuse, double release, clear
        for (int i = 0; i < 20; i++)
            push_request(dir_req[i], dir_idx[i]);
        settle_pool();

        // bounds include zero, one, the pool size and an out-of-range value;
        // some are written without a clear while slots are live
        for (int p = 0; p < 7; p++)
        begin
            if (wipe_tab[p])
            begin
                push_request(REQ_CLEAR, pick_index());
                settle_pool();
            end
            program_bound(bound_tab[p]);
            run_mix(count_tab[p], alloc_tab[p], rel_tab[p], clr_tab[p]);
            settle_pool();
        end

        if (pool.errors == 0)
            $display("free_list_index_allocator_core verification clean");
        else
            $display("free_list_index_allocator_core verification failed");
        $finish;
    end

endmodule
